// ===== rtl/core/ngfi_pkg.sv =====
// Shared constants and register codes for the normal gap fill interpolator.
package ngfi_pkg;

  // Default geometry of one normal component and the longest pending run.
  localparam int COMPONENT_BITS = 16;
  localparam int MAX_GAP        = 63;

  // Pending run count and gap (run plus one) widths.
  localparam int PEND_W = 6;
  localparam int GAP_W  = 7;

  // Configuration port.
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam int FB_W       = 16;
  localparam int THR_W      = 30;

  localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_X    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_Y    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_Z    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_VALID_THRESH  = CFG_IDX_W'(3);

  localparam logic signed [FB_W-1:0] FALLBACK_X_RST = 16'sd0;
  localparam logic signed [FB_W-1:0] FALLBACK_Y_RST = 16'sd0;
  localparam logic signed [FB_W-1:0] FALLBACK_Z_RST = 16'sd16384;
  localparam logic [THR_W-1:0]       THRESH_RST     = 30'd2;

  // A blend's squared length is scaled up until it reaches 2^NORM_EXP.
  localparam int NORM_EXP = 40;
  localparam int SH_W     = 5;

endpackage

// ===== rtl/core/ngfi_if.sv =====
// Channel interfaces: input items, result items and configuration writes.
interface ngfi_in_if #(
  parameter int CB = ngfi_pkg::COMPONENT_BITS
);
  logic                 valid;
  logic                 ready;
  logic signed [CB-1:0] in_x;
  logic signed [CB-1:0] in_y;
  logic signed [CB-1:0] in_z;
  logic                 in_final;

  modport source (output valid, in_x, in_y, in_z, in_final, input ready);
  modport sink   (input valid, in_x, in_y, in_z, in_final, output ready);
endinterface

interface ngfi_out_if #(
  parameter int CB = ngfi_pkg::COMPONENT_BITS
);
  logic                 valid;
  logic                 ready;
  logic signed [CB-1:0] out_x;
  logic signed [CB-1:0] out_y;
  logic signed [CB-1:0] out_z;
  logic                 run_end;
  logic                 array_end;
  logic                 gap_overflow;

  modport source (output valid, out_x, out_y, out_z, run_end, array_end, gap_overflow,
                  input ready);
  modport sink   (input valid, out_x, out_y, out_z, run_end, array_end, gap_overflow,
                  output ready);
endinterface

interface ngfi_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [ngfi_pkg::CFG_IDX_W-1:0]    index;
  logic [ngfi_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/ngfi_sermul.sv =====
// Bit-serial shift-and-add multiply-accumulate unit.
module ngfi_sermul #(
  parameter int AW = 8,
  parameter int BW = 8,
  parameter int PW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          clear_i,
  input  logic [AW-1:0] a_i,
  input  logic [BW-1:0] b_i,
  output logic          busy_o,
  output logic [PW-1:0] acc_o
);

  logic [PW-1:0] mcand_q, mcand_d;
  logic [PW-1:0] acc_q, acc_d;
  logic [BW-1:0] mplier_q, mplier_d;

  always_comb begin
    mcand_d  = mcand_q;
    acc_d    = acc_q;
    mplier_d = mplier_q;
    if (start_i) begin
      mcand_d  = PW'(a_i);
      mplier_d = b_i;
      if (clear_i) begin
        acc_d = '0;
      end
    end else if (mplier_q != '0) begin
      // consume one multiplier bit per cycle
      if (mplier_q[0]) begin
        acc_d = acc_q + mcand_q;
      end
      mcand_d  = mcand_q << 1;
      mplier_d = mplier_q >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mcand_q  <= '0;
      acc_q    <= '0;
      mplier_q <= '0;
    end else begin
      mcand_q  <= mcand_d;
      acc_q    <= acc_d;
      mplier_q <= mplier_d;
    end
  end

  assign busy_o = (mplier_q != '0);
  assign acc_o  = acc_q;

endmodule

// ===== rtl/core/ngfi_blend.sv =====
// Serial blend engine: normalized linear blend of two normals across a gap.
module ngfi_blend #(
  parameter int CB = ngfi_pkg::COMPONENT_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [CB-1:0]          a_i [3],
  input  logic signed [CB-1:0]          b_i [3],
  input  logic [ngfi_pkg::GAP_W-1:0]    g_i,
  input  logic [ngfi_pkg::THR_W-1:0]    thr_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output logic signed [CB-1:0]          res_o [3]
);

  localparam int FRAC = CB - 2;
  localparam int QB   = CB - 1;
  localparam int MW   = CB + 6;
  localparam int SGW  = CB + 7;
  localparam int DW   = CB + 1;
  localparam int SW   = (2 * MW + 2 > 44) ? 2 * MW + 2 : 44;
  localparam int HW   = SW / 2;
  localparam int NW   = HW + FRAC + 1;
  localparam int DCW  = $clog2(QB + 1);
  localparam int GW   = ngfi_pkg::GAP_W;

  typedef enum logic [3:0] {
    B_IDLE, B_AG, B_AGW, B_T1, B_T1W, B_T2, B_T2W, B_ADV,
    B_SQ, B_SQW, B_CMP, B_NORM, B_SQRT, B_DIVL, B_DIV, B_OUT
  } bstate_e;

  bstate_e                state_q;
  logic signed [CB-1:0]   a_q [3];
  logic signed [DW-1:0]   d_q [3];
  logic signed [SGW-1:0]  s_q [3];
  logic signed [CB-1:0]   res_q [3];
  logic [GW-1:0]          g_q, k_q;
  logic [ngfi_pkg::THR_W-1:0] thr_q;
  logic [SW-1:0]          thrg_q, sq_q;
  logic [1:0]             c_q;
  logic [ngfi_pkg::SH_W-1:0] sh_q;
  logic [SW-1:0]          n_q, r_q, bit_q;
  logic [HW-1:0]          len_q;
  logic [HW:0]            rem_q;
  logic [QB-1:0]          low_q, quo_q;
  logic [DCW-1:0]         dcnt_q;

  // multiplier control
  logic          mul_start, mul_clear, mul_busy;
  logic [SW-1:0] mul_a, mul_acc;
  logic [MW-1:0] mul_b;

  logic [CB-1:0] a_mag;
  logic [MW-1:0] s_mag;
  logic [SW:0]   rt_sum;
  logic          rt_ge;
  logic [HW-1:0] ms;
  logic [NW-1:0] num;
  logic [HW+1:0] dv_try;
  logic          dv_ge;

  assign a_mag  = a_q[c_q][CB-1] ? CB'(-a_q[c_q]) : CB'(a_q[c_q]);
  assign s_mag  = s_q[c_q][SGW-1] ? MW'(-s_q[c_q]) : MW'(s_q[c_q]);
  assign rt_sum = {1'b0, r_q} + {1'b0, bit_q};
  assign rt_ge  = ({1'b0, n_q} >= rt_sum);
  assign ms     = HW'(s_mag) << sh_q;
  assign num    = (NW'(ms) << FRAC) + NW'(len_q >> 1);
  assign dv_try = {rem_q, low_q[QB-1]};
  assign dv_ge  = (dv_try >= (HW+2)'(len_q));

  always_comb begin
    mul_start = 1'b0;
    mul_clear = 1'b1;
    mul_a     = '0;
    mul_b     = '0;
    case (state_q)
      B_AG: begin
        mul_start = 1'b1;
        mul_a     = SW'(a_mag);
        mul_b     = MW'(g_q);
      end
      B_T1: begin
        mul_start = 1'b1;
        mul_a     = SW'(thr_q);
        mul_b     = MW'(g_q);
      end
      B_T2: begin
        mul_start = 1'b1;
        mul_a     = mul_acc;
        mul_b     = MW'(g_q);
      end
      B_SQ: begin
        mul_start = 1'b1;
        mul_clear = (c_q == 2'd0);
        mul_a     = SW'(s_mag);
        mul_b     = s_mag;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  ngfi_sermul #(.AW(SW), .BW(MW), .PW(SW)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .clear_i (mul_clear),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .busy_o  (mul_busy),
    .acc_o   (mul_acc)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      c_q     <= '0;
      k_q     <= '0;
      dcnt_q  <= '0;
    end else begin
      case (state_q)
        B_IDLE: begin
          if (start_i) begin
            for (int c = 0; c < 3; c++) begin
              a_q[c] <= a_i[c];
              d_q[c] <= DW'(b_i[c]) - DW'(a_i[c]);
            end
            g_q     <= g_i;
            k_q     <= g_i - GW'(1);
            thr_q   <= thr_i;
            c_q     <= '0;
            state_q <= B_AG;
          end
        end
        B_AG: state_q <= B_AGW;
        B_AGW: begin
          if (!mul_busy) begin
            s_q[c_q] <= a_q[c_q][CB-1] ? -$signed(SGW'(mul_acc)) : $signed(SGW'(mul_acc));
            if (c_q == 2'd2) begin
              state_q <= B_T1;
            end else begin
              c_q     <= c_q + 2'd1;
              state_q <= B_AG;
            end
          end
        end
        B_T1: state_q <= B_T1W;
        B_T1W: begin
          if (!mul_busy) begin
            state_q <= B_T2;
          end
        end
        B_T2: state_q <= B_T2W;
        B_T2W: begin
          if (!mul_busy) begin
            thrg_q  <= mul_acc;
            state_q <= B_ADV;
          end
        end
        B_ADV: begin
          // step the blend sum by one gap position
          for (int c = 0; c < 3; c++) begin
            s_q[c] <= s_q[c] + SGW'(d_q[c]);
          end
          c_q     <= '0;
          state_q <= B_SQ;
        end
        B_SQ: state_q <= B_SQW;
        B_SQW: begin
          if (!mul_busy) begin
            if (c_q == 2'd2) begin
              sq_q    <= mul_acc;
              state_q <= B_CMP;
            end else begin
              c_q     <= c_q + 2'd1;
              state_q <= B_SQ;
            end
          end
        end
        B_CMP: begin
          if (sq_q <= thrg_q) begin
            // too short to normalize: hold the previous normal
            for (int c = 0; c < 3; c++) begin
              res_q[c] <= a_q[c];
            end
            state_q <= B_OUT;
          end else begin
            sh_q    <= '0;
            state_q <= B_NORM;
          end
        end
        B_NORM: begin
          if (sq_q[SW-1:ngfi_pkg::NORM_EXP] == '0) begin
            sq_q <= sq_q << 2;
            sh_q <= sh_q + 1'b1;
          end else begin
            n_q     <= sq_q;
            r_q     <= '0;
            bit_q   <= SW'(1) << (SW - 2);
            state_q <= B_SQRT;
          end
        end
        B_SQRT: begin
          if (bit_q == '0) begin
            len_q   <= r_q[HW-1:0];
            c_q     <= '0;
            state_q <= B_DIVL;
          end else begin
            if (rt_ge) begin
              n_q <= n_q - rt_sum[SW-1:0];
              r_q <= (r_q >> 1) + bit_q;
            end else begin
              r_q <= r_q >> 1;
            end
            bit_q <= bit_q >> 2;
          end
        end
        B_DIVL: begin
          rem_q   <= (HW+1)'(num >> QB);
          low_q   <= num[QB-1:0];
          quo_q   <= '0;
          dcnt_q  <= DCW'(QB);
          state_q <= B_DIV;
        end
        B_DIV: begin
          if (dcnt_q == '0) begin
            res_q[c_q] <= s_q[c_q][SGW-1] ? -$signed(CB'(quo_q)) : $signed(CB'(quo_q));
            if (c_q == 2'd2) begin
              state_q <= B_OUT;
            end else begin
              c_q     <= c_q + 2'd1;
              state_q <= B_DIVL;
            end
          end else begin
            rem_q  <= dv_ge ? (HW+1)'(dv_try - (HW+2)'(len_q)) : (HW+1)'(dv_try);
            quo_q  <= {quo_q[QB-2:0], dv_ge};
            low_q  <= low_q << 1;
            dcnt_q <= dcnt_q - 1'b1;
          end
        end
        B_OUT: begin
          if (res_ready_i) begin
            if (k_q == GW'(1)) begin
              state_q <= B_IDLE;
            end else begin
              k_q     <= k_q - GW'(1);
              state_q <= B_ADV;
            end
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  assign res_valid_o = (state_q == B_OUT);
  assign res_o       = res_q;

endmodule

// ===== rtl/core/normal_gap_fill_interpolator_unit.sv =====
// Top level of the normal gap fill interpolator.
//
// Channels: in_i takes one normal (x, y, z in signed Q1.14, plus a flag for
// the last normal of the array); out_o gives repaired normals, each tagged
// with run_end (last result of that input), array_end and gap_overflow;
// cfg_i writes the fallback normal (index 0..2) and the validity threshold
// (index 3), and is always ready.
// One item is taken at a time. After a transfer the squared length is built
// by a bit-serial multiply-accumulate. Copies (held, first-valid, fallback,
// overflow flush) and the valid normal itself then leave at one result per
// cycle while the receiver takes them. Each blended result inside a gap
// comes from the serial blend engine: squaring, scaling, square root and
// restoring division, plus setup per run.
// A result waits in the output register while the receiver stalls; the
// engine and the copy sequencer pause until it is taken.
// Reset returns the fallback to (0, 0, 1.0), the threshold to 2 and clears
// the held normal and the pending run count; no clearing pass is needed.
module normal_gap_fill_interpolator_unit #(
  parameter int COMPONENT_BITS = ngfi_pkg::COMPONENT_BITS,
  parameter int MAX_GAP        = ngfi_pkg::MAX_GAP
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ngfi_in_if.sink    in_i,
  ngfi_out_if.source out_o,
  ngfi_cfg_if.sink   cfg_i
);

  localparam int CB  = COMPONENT_BITS;
  localparam int PW  = 2 * CB + 2;
  localparam int CW  = (PW > ngfi_pkg::THR_W) ? PW : ngfi_pkg::THR_W;
  localparam int PDW = ngfi_pkg::PEND_W;
  localparam int GW  = ngfi_pkg::GAP_W;

  typedef enum logic [2:0] {
    T_IDLE, T_SQ, T_SQW, T_CLS, T_BLEND, T_COPY
  } tstate_e;

  tstate_e               state_q;
  logic signed [CB-1:0]  cur_q [3];
  logic signed [CB-1:0]  held_q [3];
  logic signed [CB-1:0]  copy_q [3];
  logic                  final_q;
  logic                  seen_q;
  logic [PDW-1:0]        pend_q;
  logic [GW-1:0]         cnt_q;
  logic                  ovf_q;
  logic [1:0]            c_q;

  logic signed [ngfi_pkg::FB_W-1:0] fb_q [3];
  logic [ngfi_pkg::THR_W-1:0]       thr_q;

  // output register
  logic                  ovalid_q;
  logic signed [CB-1:0]  ores_q [3];
  logic                  orun_q, oarr_q, oovf_q;

  logic                  can_load;
  logic                  sq_busy;
  logic [PW-1:0]         sq_acc;
  logic [CB-1:0]         cur_mag;
  logic                  is_valid;
  logic signed [CB-1:0]  src [3];
  logic                  b_start, b_res_valid, b_res_ready;
  logic signed [CB-1:0]  b_res [3];
  logic signed [CB-1:0]  in_vec [3];

  assign can_load = !ovalid_q || out_o.ready;
  assign cur_mag  = cur_q[c_q][CB-1] ? CB'(-cur_q[c_q]) : CB'(cur_q[c_q]);
  assign is_valid = (CW'(sq_acc) > CW'(thr_q));
  assign in_vec[0] = in_i.in_x;
  assign in_vec[1] = in_i.in_y;
  assign in_vec[2] = in_i.in_z;

  // copy source: last valid normal, or the fallback before any was seen
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      src[c] = seen_q ? held_q[c] : CB'(fb_q[c]);
    end
  end

  ngfi_sermul #(.AW(CB), .BW(CB), .PW(PW)) u_sqlen (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == T_SQ),
    .clear_i (c_q == 2'd0),
    .a_i     (cur_mag),
    .b_i     (cur_mag),
    .busy_o  (sq_busy),
    .acc_o   (sq_acc)
  );

  assign b_start     = (state_q == T_CLS) && is_valid && seen_q && (pend_q != '0);
  assign b_res_ready = (state_q == T_BLEND) && can_load;

  ngfi_blend #(.CB(CB)) u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (b_start),
    .a_i         (held_q),
    .b_i         (cur_q),
    .g_i         (GW'(pend_q) + GW'(1)),
    .thr_i       (thr_q),
    .res_valid_o (b_res_valid),
    .res_ready_i (b_res_ready),
    .res_o       (b_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= T_IDLE;
      ovalid_q <= 1'b0;
      seen_q   <= 1'b0;
      pend_q   <= '0;
      cnt_q    <= '0;
      c_q      <= '0;
      final_q  <= 1'b0;
      ovf_q    <= 1'b0;
      for (int c = 0; c < 3; c++) begin
        held_q[c] <= '0;
      end
      fb_q[0]  <= ngfi_pkg::FALLBACK_X_RST;
      fb_q[1]  <= ngfi_pkg::FALLBACK_Y_RST;
      fb_q[2]  <= ngfi_pkg::FALLBACK_Z_RST;
      thr_q    <= ngfi_pkg::THRESH_RST;
    end else begin
      // configuration writes
      if (cfg_i.valid) begin
        case (cfg_i.index)
          ngfi_pkg::CFG_FALLBACK_X:   fb_q[0] <= cfg_i.data[ngfi_pkg::FB_W-1:0];
          ngfi_pkg::CFG_FALLBACK_Y:   fb_q[1] <= cfg_i.data[ngfi_pkg::FB_W-1:0];
          ngfi_pkg::CFG_FALLBACK_Z:   fb_q[2] <= cfg_i.data[ngfi_pkg::FB_W-1:0];
          ngfi_pkg::CFG_VALID_THRESH: thr_q   <= cfg_i.data[ngfi_pkg::THR_W-1:0];
          default: ;
        endcase
      end

      // drop a result once the receiver takes it
      if (ovalid_q && out_o.ready) begin
        ovalid_q <= 1'b0;
      end

      case (state_q)
        T_IDLE: begin
          if (in_i.valid) begin
            cur_q   <= in_vec;
            final_q <= in_i.in_final;
            c_q     <= '0;
            state_q <= T_SQ;
          end
        end
        T_SQ: state_q <= T_SQW;
        T_SQW: begin
          if (!sq_busy) begin
            if (c_q == 2'd2) begin
              state_q <= T_CLS;
            end else begin
              c_q     <= c_q + 2'd1;
              state_q <= T_SQ;
            end
          end
        end
        T_CLS: begin
          ovf_q <= 1'b0;
          if (is_valid) begin
            held_q <= cur_q;
            seen_q <= 1'b1;
            pend_q <= '0;
            copy_q <= cur_q;
            if (seen_q && pend_q != '0) begin
              cnt_q   <= GW'(pend_q);
              state_q <= T_BLEND;
            end else begin
              // leading run copies the first valid normal, then itself
              cnt_q   <= GW'(pend_q) + GW'(1);
              state_q <= T_COPY;
            end
          end else if (pend_q >= PDW'(MAX_GAP)) begin
            copy_q  <= src;
            ovf_q   <= 1'b1;
            cnt_q   <= GW'(pend_q) + GW'(1);
            pend_q  <= '0;
            state_q <= T_COPY;
          end else if (final_q) begin
            copy_q  <= src;
            cnt_q   <= GW'(pend_q) + GW'(1);
            pend_q  <= '0;
            state_q <= T_COPY;
          end else begin
            pend_q  <= pend_q + 1'b1;
            state_q <= T_IDLE;
          end
          // end of array: start the next one from reset values
          if (final_q) begin
            seen_q <= 1'b0;
            pend_q <= '0;
            for (int c = 0; c < 3; c++) begin
              held_q[c] <= '0;
            end
          end
        end
        T_BLEND: begin
          if (b_res_valid && can_load) begin
            ovalid_q <= 1'b1;
            ores_q   <= b_res;
            orun_q   <= 1'b0;
            oarr_q   <= 1'b0;
            oovf_q   <= 1'b0;
            if (cnt_q == GW'(1)) begin
              state_q <= T_COPY;
            end else begin
              cnt_q <= cnt_q - GW'(1);
            end
          end
        end
        T_COPY: begin
          if (can_load) begin
            ovalid_q <= 1'b1;
            ores_q   <= copy_q;
            orun_q   <= (cnt_q == GW'(1));
            oarr_q   <= final_q && (cnt_q == GW'(1));
            oovf_q   <= ovf_q;
            if (cnt_q == GW'(1)) begin
              state_q <= T_IDLE;
            end else begin
              cnt_q <= cnt_q - GW'(1);
            end
          end
        end
        default: state_q <= T_IDLE;
      endcase
    end
  end

  assign in_i.ready         = (state_q == T_IDLE);
  assign cfg_i.ready        = 1'b1;
  assign out_o.valid        = ovalid_q;
  assign out_o.out_x        = ores_q[0];
  assign out_o.out_y        = ores_q[1];
  assign out_o.out_z        = ores_q[2];
  assign out_o.run_end      = orun_q;
  assign out_o.array_end    = oarr_q;
  assign out_o.gap_overflow = oovf_q;

  // Blend results only appear while the sequencer forwards them.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_res_valid |-> state_q == T_BLEND)
    else $error("blend result outside of blend phase");

  // The pending run never grows past its limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= PDW'(MAX_GAP))
    else $error("pending run above limit");

  // The end of an array is always the end of its item's results.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && oarr_q) |-> orun_q)
    else $error("array end without run end");

  // A finished array leaves no valid normal behind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == T_COPY && can_load && cnt_q == GW'(1) && final_q) |=> !seen_q)
    else $error("held state survives end of array");

endmodule
